>>> src/pixel_sprite_collision_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sprite collision core
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef PIXEL_SPRITE_COLLISION_CORE_MACROS_SVH
`define PIXEL_SPRITE_COLLISION_CORE_MACROS_SVH

// assert a property on every rising edge outside reset
`define PSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// assert an implication on every rising edge outside reset
`define PSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the sprite collision core.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int MAX_SPRITE_W_DEF = 64;
    localparam int MAX_SPRITE_H_DEF = 64;

    localparam int COORD_W   = 14;
    localparam int POS_W     = 12;
    localparam int SIZE_W    = 7;
    localparam int PIX_W     = 32;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_WR_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS = 3'd7;

    localparam logic [SIZE_W-1:0] SIZE_RST  = 7'd64;
    localparam logic [PIX_W-1:0]  ALPHA_RST = 32'hFF00_0000;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic load_pos;
        logic box;
        logic init;
        logic issue;
        logic out_load;
        logic out_hit;
    } t_psc_cmd;

    typedef struct packed {
        logic empty;
        logic last_pix;
        logic pair_hit;
    } t_psc_sts;

endpackage

>>> src/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer for pixel loads and overlap scans of the collision core.
// ----------------------------------------------------------------------------
module psc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [psc_pkg::KIND_W-1:0]   i_kind,
    output logic                         o_s_tready,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  psc_pkg::t_psc_sts            i_sts,
    output psc_pkg::t_psc_cmd            o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_hit, n_hit;
    logic   r_m_tvalid, n_m_tvalid;
    logic   s_accept;
    logic   out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid = r_m_tvalid;

    always_comb begin
        n_state    = r_state;
        n_hit      = r_hit;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        o_cmd      = '0;
        o_cmd.out_hit = r_hit;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (i_kind)
                        psc_pkg::KIND_WR_A:  o_cmd.wr_a = 1'b1;
                        psc_pkg::KIND_WR_B:  o_cmd.wr_b = 1'b1;
                        psc_pkg::KIND_CHECK: begin
                            o_cmd.load_pos = 1'b1;
                            n_state        = ST_BOX;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BOX: begin
                o_cmd.box = 1'b1;
                n_state   = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_hit      = 1'b0;
                n_state    = i_sts.empty ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.pair_hit) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (i_sts.last_pix) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_hit   = i_sts.pair_hit;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_m_tvalid     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_hit      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hit      <= n_hit;
            r_m_tvalid <= n_m_tvalid;
        end
    end

endmodule

>>> src/psc_datapath.sv
// ----------------------------------------------------------------------------
// psc_datapath
// Sprite stores, configuration, overlap box, scan counters and result word.
// ----------------------------------------------------------------------------
module psc_datapath #(
    parameter int MAX_SPRITE_W = psc_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = psc_pkg::MAX_SPRITE_H_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [psc_pkg::PIX_W-1:0]         i_cfg_wdata,
    input  logic [psc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  psc_pkg::t_psc_cmd                 i_cmd,
    output psc_pkg::t_psc_sts                 o_sts,
    output logic [psc_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int DEPTH = MAX_SPRITE_W * MAX_SPRITE_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAW   = $clog2(MAX_SPRITE_W);
    localparam int RAW   = $clog2(MAX_SPRITE_H);
    localparam int CW    = psc_pkg::COORD_W;
    localparam int PW    = psc_pkg::PIX_W;
    localparam int SW    = psc_pkg::SIZE_W;
    localparam int QW    = psc_pkg::POS_W;

    logic [SW-1:0] r_width_a, r_height_a, r_width_b, r_height_b;
    logic [PW-1:0] r_key_a, r_key_b, r_alpha_mask;
    logic [3:0]    r_mode_flags;

    logic [PW-1:0] r_mem_a [0:DEPTH-1];
    logic [PW-1:0] r_mem_b [0:DEPTH-1];
    logic [PW-1:0] r_rd_a, r_rd_b;
    logic          r_rd_vld;

    logic [5:0]    in_col, in_row;
    logic [PW-1:0] in_val;
    logic          wr_in_range;
    logic [AW-1:0] wr_addr;

    logic signed [QW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [CW-1:0] ax_e, ay_e, bx_e, by_e;
    logic signed [CW-1:0] wa, ha, wb, hb;
    logic signed [CW-1:0] xa_end, ya_end, xb_end, yb_end;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [CW-1:0] d_ca0, d_cb0, d_ra0, d_rb0, d_ca_last, d_ra_last;
    logic signed [CW-1:0] ovl_w, ovl_h;

    logic [CAW-1:0] r_ca, r_cb, r_ca0, r_cb0, r_ca_last;
    logic [RAW-1:0] r_ra, r_rb, r_ra_last;
    logic [AW-1:0]  rd_addr_a, rd_addr_b;
    logic           trans_a, trans_b;
    logic           col_end;

    logic [psc_pkg::OUT_DATA_W-1:0] r_out;

    assign in_col = i_s_tdata[5:0];
    assign in_row = i_s_tdata[11:6];
    assign in_val = i_s_tdata[43:12];
    assign wr_in_range = (32'(in_col) < MAX_SPRITE_W) && (32'(in_row) < MAX_SPRITE_H);
    assign wr_addr = AW'(32'(in_row) * MAX_SPRITE_W + 32'(in_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_a    <= psc_pkg::SIZE_RST;
            r_height_a   <= psc_pkg::SIZE_RST;
            r_width_b    <= psc_pkg::SIZE_RST;
            r_height_b   <= psc_pkg::SIZE_RST;
            r_key_a      <= '0;
            r_key_b      <= '0;
            r_alpha_mask <= psc_pkg::ALPHA_RST;
            r_mode_flags <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                psc_pkg::REG_WIDTH_A:    r_width_a    <= i_cfg_wdata[SW-1:0];
                psc_pkg::REG_HEIGHT_A:   r_height_a   <= i_cfg_wdata[SW-1:0];
                psc_pkg::REG_WIDTH_B:    r_width_b    <= i_cfg_wdata[SW-1:0];
                psc_pkg::REG_HEIGHT_B:   r_height_b   <= i_cfg_wdata[SW-1:0];
                psc_pkg::REG_KEY_A:      r_key_a      <= i_cfg_wdata;
                psc_pkg::REG_KEY_B:      r_key_b      <= i_cfg_wdata;
                psc_pkg::REG_ALPHA_MASK: r_alpha_mask <= i_cfg_wdata;
                psc_pkg::REG_MODE_FLAGS: r_mode_flags <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // pixel stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && wr_in_range) begin
            r_mem_a[wr_addr] <= in_val;
        end
        if (i_cmd.issue) begin
            r_rd_a <= r_mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b && wr_in_range) begin
            r_mem_b[wr_addr] <= in_val;
        end
        if (i_cmd.issue) begin
            r_rd_b <= r_mem_b[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
        end
    end

    // overlap box
    assign ax_e = CW'(r_ax);
    assign ay_e = CW'(r_ay);
    assign bx_e = CW'(r_bx);
    assign by_e = CW'(r_by);

    assign wa = $signed((32'(r_width_a) > MAX_SPRITE_W) ? CW'(MAX_SPRITE_W) : CW'(r_width_a));
    assign ha = $signed((32'(r_height_a) > MAX_SPRITE_H) ? CW'(MAX_SPRITE_H) : CW'(r_height_a));
    assign wb = $signed((32'(r_width_b) > MAX_SPRITE_W) ? CW'(MAX_SPRITE_W) : CW'(r_width_b));
    assign hb = $signed((32'(r_height_b) > MAX_SPRITE_H) ? CW'(MAX_SPRITE_H) : CW'(r_height_b));

    assign xa_end = ax_e + wa;
    assign ya_end = ay_e + ha;
    assign xb_end = bx_e + wb;
    assign yb_end = by_e + hb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pos) begin
            r_ax <= $signed(i_s_tdata[55:44]);
            r_ay <= $signed(i_s_tdata[67:56]);
            r_bx <= $signed(i_s_tdata[79:68]);
            r_by <= $signed(i_s_tdata[91:80]);
        end
        if (i_cmd.box) begin
            r_x0 <= (ax_e > bx_e) ? ax_e : bx_e;
            r_y0 <= (ay_e > by_e) ? ay_e : by_e;
            r_x1 <= (xa_end < xb_end) ? xa_end : xb_end;
            r_y1 <= (ya_end < yb_end) ? ya_end : yb_end;
        end
    end

    // scan counters
    assign d_ca0     = r_x0 - ax_e;
    assign d_cb0     = r_x0 - bx_e;
    assign d_ra0     = r_y0 - ay_e;
    assign d_rb0     = r_y0 - by_e;
    assign d_ca_last = r_x1 - ax_e - CW'(1);
    assign d_ra_last = r_y1 - ay_e - CW'(1);
    assign ovl_w     = r_x1 - r_x0;
    assign ovl_h     = r_y1 - r_y0;
    assign col_end   = (r_ca == r_ca_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_ca      <= d_ca0[CAW-1:0];
            r_cb      <= d_cb0[CAW-1:0];
            r_ca0     <= d_ca0[CAW-1:0];
            r_cb0     <= d_cb0[CAW-1:0];
            r_ra      <= d_ra0[RAW-1:0];
            r_rb      <= d_rb0[RAW-1:0];
            r_ca_last <= d_ca_last[CAW-1:0];
            r_ra_last <= d_ra_last[RAW-1:0];
        end else if (i_cmd.issue) begin
            if (col_end) begin
                r_ca <= r_ca0;
                r_cb <= r_cb0;
                r_ra <= r_ra + RAW'(1);
                r_rb <= r_rb + RAW'(1);
            end else begin
                r_ca <= r_ca + CAW'(1);
                r_cb <= r_cb + CAW'(1);
            end
        end
    end

    assign rd_addr_a = AW'(32'(r_ra) * MAX_SPRITE_W + 32'(r_ca));
    assign rd_addr_b = AW'(32'(r_rb) * MAX_SPRITE_W + 32'(r_cb));

    assign trans_a = (r_mode_flags[0] && (r_rd_a == r_key_a))
                  || (r_mode_flags[2] && ((r_rd_a & r_alpha_mask) == '0));
    assign trans_b = (r_mode_flags[1] && (r_rd_b == r_key_b))
                  || (r_mode_flags[3] && ((r_rd_b & r_alpha_mask) == '0));

    assign o_sts.empty    = (ovl_w <= CW'(0)) || (ovl_h <= CW'(0));
    assign o_sts.last_pix = col_end && (r_ra == r_ra_last);
    assign o_sts.pair_hit = r_rd_vld && !trans_a && !trans_b;

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_hit) begin
                r_out <= {1'b0, ovl_h[SW-1:0], ovl_w[SW-1:0],
                          r_y0[QW-1:0], r_x0[QW-1:0], 1'b1};
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_m_tdata = r_out;

endmodule

>>> src/pixel_sprite_collision_core.sv
// ----------------------------------------------------------------------------
// pixel_sprite_collision_core
// Per-pixel collision test of two stored sprite images.
// ----------------------------------------------------------------------------
// Input stream words carry a kind in s_tuser: write a pixel of sprite A,
// write a pixel of sprite B, or run a collision check at the given world
// corners. Pixel writes give no output word; another input word is taken
// on the next cycle. A check gives one output word: the collided flag and,
// on a hit, the overlap rectangle (all zero if not). A check latches the
// corners, forms the overlap box, starts the scan counters, scans n overlap
// positions (at most 64 x 64 at the default size) and loads the result; it
// skips the scan when the two boxes do not overlap. The scan reads one pixel
// pair per cycle from the two stores and stops at the first pair opaque in
// both sprites. No input is taken while a check runs. The result sits in an
// output register, so a new word is taken while the result waits; a check
// finishing under a stalled output holds until the register frees. Reset
// sets the configuration registers to their defaults and empties the output;
// store contents are unknown until written. Configuration is written through
// cfg_we/addr/wdata by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "pixel_sprite_collision_core_macros.svh"

module pixel_sprite_collision_core #(
    parameter int MAX_SPRITE_W = psc_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = psc_pkg::MAX_SPRITE_H_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [psc_pkg::PIX_W-1:0]         i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pix_col, pix_row, pix_value, pos_ax, pos_ay, pos_bx, pos_by, zero pad
    input  logic [psc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // kind
    input  logic [psc_pkg::KIND_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // collided, overlap_x, overlap_y, overlap_w, overlap_h, zero pad
    output logic [psc_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    psc_pkg::t_psc_cmd cmd;
    psc_pkg::t_psc_sts sts;

    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    psc_datapath #(
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tdata   (o_m_tdata)
    );

    `PSC_ASSERT(a_no_load_while_full, !(cmd.out_load && o_m_tvalid && !i_m_tready), "overrun")
    `PSC_ASSERT(a_issue_not_idle, !(cmd.issue && o_s_tready), "scan read issued while input open")
    `PSC_ASSERT_IMP(a_miss_is_zero, o_m_tvalid && !o_m_tdata[0], ~|o_m_tdata[38:1], "dirty miss")
    `PSC_ASSERT_IMP(a_hit_has_w, o_m_tvalid && o_m_tdata[0], |o_m_tdata[31:25], "no hit width")
    `PSC_ASSERT_IMP(a_hit_has_h, o_m_tvalid && o_m_tdata[0], |o_m_tdata[38:32], "no hit height")

endmodule

>>> sim/pixel_sprite_collision_core_tb.sv
// ----------------------------------------------------------------------------
// pixel_sprite_collision_core_tb
// Self-checking bench for the per-pixel sprite collision core. A directed
// table covers the register extremes, the position limits, edge contact,
// containment, colour keys and alpha masks. Random phases follow, with
// sender gaps and receiver stalls. Pixels a check scans up to its first hit
// are loaded first. Directed checks mostly hold their expected result and
// a scan model predicts the rest, checked field by field on the output word.
// ----------------------------------------------------------------------------
module pixel_sprite_collision_core_tb;
    import psc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SPR_W = MAX_SPRITE_W_DEF;
    localparam int SPR_H = MAX_SPRITE_H_DEF;
    localparam int DEPTH = SPR_W * SPR_H;
    localparam int POS_LSB = 44;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int GAP_PCT[4] = '{0, 49, 0, 33};
    localparam int STALL_PCT[4] = '{0, 0, 49, 33};

    typedef struct packed {
        logic                    collided;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic [SIZE_W-1:0]       ow;
        logic [SIZE_W-1:0]       oh;
    } hit_rect_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_op_e;

    typedef struct {
        row_op_e                op;
        logic [CFG_IDX_W-1:0]   idx;
        logic [PIX_W-1:0]       val;
        logic [KIND_W-1:0]      kind;
        logic [IN_DATA_W-1:0]   data;
        bit                     typed;
        hit_rect_t              exp;
    } stim_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [PIX_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // pix_col, pix_row, pix_value, pos_ax, pos_ay, pos_bx, pos_by, zero pad
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    // kind
    logic [KIND_W-1:0]      i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // collided, overlap_x, overlap_y, overlap_w, overlap_h, zero pad
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    logic [SIZE_W-1:0] r_wa = SIZE_RST;
    logic [SIZE_W-1:0] r_ha = SIZE_RST;
    logic [SIZE_W-1:0] r_wb = SIZE_RST;
    logic [SIZE_W-1:0] r_hb = SIZE_RST;
    logic [PIX_W-1:0]  r_key_a = '0;
    logic [PIX_W-1:0]  r_key_b = '0;
    logic [PIX_W-1:0]  r_alpha = ALPHA_RST;
    logic [3:0]        r_mode = '0;

    logic [PIX_W-1:0] store_a [DEPTH];
    logic [PIX_W-1:0] store_b [DEPTH];
    bit               seen_a [DEPTH];
    bit               seen_b [DEPTH];

    hit_rect_t pending_results[$];
    stim_row_t plan[$];

    int errors = 0;
    int n_words = 0;
    int n_checks = 0;
    int n_hits = 0;
    int n_misses = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int quiet = 0;

    pixel_sprite_collision_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int eff_size(logic [SIZE_W-1:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic void overlap_box(input int ax, ay, bx, by,
                                        output int x0, y0, x1, y1);
        int wa, ha, wb, hb;
        wa = eff_size(r_wa, SPR_W);
        ha = eff_size(r_ha, SPR_H);
        wb = eff_size(r_wb, SPR_W);
        hb = eff_size(r_hb, SPR_H);
        x0 = (ax > bx) ? ax : bx;
        y0 = (ay > by) ? ay : by;
        x1 = (ax + wa < bx + wb) ? ax + wa : bx + wb;
        y1 = (ay + ha < by + hb) ? ay + ha : by + hb;
    endfunction

    function automatic int store_addr(int x, int y, int cx, int cy);
        return ((y - cy) * SPR_W + (x - cx)) & (DEPTH - 1);
    endfunction

    function automatic bit is_opaque(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] key,
                                     logic key_on, logic blend_on);
        return !((key_on && pix == key) || (blend_on && (pix & r_alpha) == '0));
    endfunction

    function automatic bit pair_opaque(int ia, int ib);
        return is_opaque(store_a[ia], r_key_a, r_mode[0], r_mode[2]) &&
               is_opaque(store_b[ib], r_key_b, r_mode[1], r_mode[3]);
    endfunction

    function automatic hit_rect_t rect(int x, int y, int w, int h);
        hit_rect_t r;
        r.collided = 1'b1;
        r.ox = POS_W'(x);
        r.oy = POS_W'(y);
        r.ow = SIZE_W'(w);
        r.oh = SIZE_W'(h);
        return r;
    endfunction

    function automatic hit_rect_t collision_scan(int ax, int ay, int bx, int by);
        int x0, y0, x1, y1, x, y;
        bit hit;
        hit = 1'b0;
        overlap_box(ax, ay, bx, by, x0, y0, x1, y1);
        for (y = y0; y < y1 && !hit; y++)
            for (x = x0; x < x1 && !hit; x++)
                hit = pair_opaque(store_addr(x, y, ax, ay), store_addr(x, y, bx, by));
        return hit ? rect(x0, y0, x1 - x0, y1 - y0) : hit_rect_t'('0);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_word(int col, int row,
                                                       logic [PIX_W-1:0] pix,
                                                       int ax, int ay, int bx, int by);
        return IN_DATA_W'({POS_W'(by), POS_W'(bx), POS_W'(ay), POS_W'(ax),
                           pix, 6'(row), 6'(col)});
    endfunction

    function automatic int pos_of(logic [IN_DATA_W-1:0] d, int k);
        logic signed [POS_W-1:0] p;
        p = d[POS_LSB + POS_W * k +: POS_W];
        return int'(p);
    endfunction

    function automatic hit_rect_t unpack_rect(logic [OUT_DATA_W-1:0] d);
        hit_rect_t r;
        r.collided = d[0];
        r.ox = d[12:1];
        r.oy = d[24:13];
        r.ow = d[31:25];
        r.oh = d[38:32];
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] key);
        case ($urandom_range(7))
            0, 1: return key;
            2: return $urandom & ~r_alpha;
            3: return '0;
            4: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(19))
            0: return '0;
            1: return SIZE_W'($urandom_range(65, 127));
            2: return SIZE_RST;
            default: return SIZE_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_word32();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return ALPHA_RST;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pos();
        logic signed [POS_W-1:0] p;
        p = POS_W'($urandom);
        return int'(p);
    endfunction

    function automatic int clamp_pos(int v);
        return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
        stim_row_t s;
        s.op = ROW_REG;
        s.idx = idx;
        s.val = val;
        s.kind = KIND_UNUSED;
        s.data = '0;
        s.typed = 1'b0;
        s.exp = '0;
        plan.push_back(s);
    endfunction

    function automatic void plan_word(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data,
                                      bit typed = 1'b0, hit_rect_t exp = '0);
        stim_row_t s;
        s.op = ROW_WORD;
        s.idx = '0;
        s.val = '0;
        s.kind = kind;
        s.data = data;
        s.typed = typed;
        s.exp = exp;
        plan.push_back(s);
    endfunction

    function automatic void plan_check(int ax, int ay, int bx, int by,
                                       bit typed = 1'b0, hit_rect_t exp = '0);
        plan_word(KIND_CHECK, pack_word(0, 0, '0, ax, ay, bx, by), typed, exp);
    endfunction

    task automatic take_word(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data,
                             bit typed, hit_rect_t exp);
        int idx;
        idx = int'(data[11:6]) * SPR_W + int'(data[5:0]);
        case (kind)
            KIND_WR_A: begin
                store_a[idx] = data[43:12];
                seen_a[idx] = 1'b1;
            end
            KIND_WR_B: begin
                store_b[idx] = data[43:12];
                seen_b[idx] = 1'b1;
            end
            KIND_CHECK: begin
                n_checks++;
                pending_results.push_back(typed ? exp :
                    collision_scan(pos_of(data, 0), pos_of(data, 1),
                                   pos_of(data, 2), pos_of(data, 3)));
            end
            default: ;
        endcase
    endtask

    task automatic send_word(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data,
                             bit typed = 1'b0, hit_rect_t exp = '0);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= data;
        do @(posedge i_clk); while (!o_s_tready);
        take_word(kind, data, typed, exp);
        n_words++;
        @(negedge i_clk);
    endtask

    // load every pixel the scan visits up to its first hit before the check goes out
    task automatic prime_scan(int ax, int ay, int bx, int by);
        int x0, y0, x1, y1, x, y, ia, ib;
        bit hit;
        hit = 1'b0;
        overlap_box(ax, ay, bx, by, x0, y0, x1, y1);
        for (y = y0; y < y1 && !hit; y++)
            for (x = x0; x < x1 && !hit; x++) begin
                ia = store_addr(x, y, ax, ay);
                ib = store_addr(x, y, bx, by);
                if (!seen_a[ia])
                    send_word(KIND_WR_A, pack_word(ia % SPR_W, ia / SPR_W,
                                                   pick_pixel(r_key_a), 0, 0, 0, 0));
                if (!seen_b[ib])
                    send_word(KIND_WR_B, pack_word(ib % SPR_W, ib / SPR_W,
                                                   pick_pixel(r_key_b), 0, 0, 0, 0));
                hit = pair_opaque(ia, ib);
            end
    endtask

    task automatic issue(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data,
                         bit typed = 1'b0, hit_rect_t exp = '0);
        if (kind == KIND_CHECK)
            prime_scan(pos_of(data, 0), pos_of(data, 1), pos_of(data, 2), pos_of(data, 3));
        send_word(kind, data, typed, exp);
    endtask

    // hold input until every result is out, then let pixel writes settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_WIDTH_A:    r_wa = val[SIZE_W-1:0];
            REG_HEIGHT_A:   r_ha = val[SIZE_W-1:0];
            REG_WIDTH_B:    r_wb = val[SIZE_W-1:0];
            REG_HEIGHT_B:   r_hb = val[SIZE_W-1:0];
            REG_KEY_A:      r_key_a = val;
            REG_KEY_B:      r_key_b = val;
            REG_ALPHA_MASK: r_alpha = val;
            REG_MODE_FLAGS: r_mode = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic shuffle_regs();
        reg_write(REG_WIDTH_A, PIX_W'(pick_size()));
        reg_write(REG_HEIGHT_A, PIX_W'(pick_size()));
        reg_write(REG_WIDTH_B, PIX_W'(pick_size()));
        reg_write(REG_HEIGHT_B, PIX_W'(pick_size()));
        reg_write(REG_KEY_A, pick_word32());
        reg_write(REG_KEY_B, pick_word32());
        reg_write(REG_ALPHA_MASK, pick_word32());
        reg_write(REG_MODE_FLAGS, PIX_W'($urandom_range(15)));
    endtask

    task automatic random_word();
        logic [KIND_W-1:0] kind;
        int pick, w, h, wa, ha, wb, hb, ax, ay, bx, by;
        pick = $urandom_range(99);
        wa = eff_size(r_wa, SPR_W);
        ha = eff_size(r_ha, SPR_H);
        wb = eff_size(r_wb, SPR_W);
        hb = eff_size(r_hb, SPR_H);
        if (pick < 35) begin
            kind = $urandom_range(1) ? KIND_WR_A : KIND_WR_B;
            w = (kind == KIND_WR_A) ? wa : wb;
            h = (kind == KIND_WR_A) ? ha : hb;
            if (pick >= 30 || w == 0 || h == 0) begin
                w = SPR_W;
                h = SPR_H;
            end
            issue(kind, pack_word($urandom_range(w - 1), $urandom_range(h - 1),
                                  pick_pixel(kind == KIND_WR_A ? r_key_a : r_key_b),
                                  $urandom, $urandom, $urandom, $urandom));
        end else begin
            ax = pick_pos();
            ay = pick_pos();
            if (pick < 90) begin
                bx = clamp_pos(ax + int'($urandom_range(wa + wb)) - wb);
                by = clamp_pos(ay + int'($urandom_range(ha + hb)) - hb);
            end else begin
                bx = pick_pos();
                by = pick_pos();
            end
            issue(KIND_CHECK, pack_word($urandom_range(63), $urandom_range(63), $urandom,
                                        ax, ay, bx, by));
        end
    endtask

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        hit_rect_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = unpack_rect(o_m_tdata);
            if (got.collided === 1'b1)
                n_hits++;
            else
                n_misses++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, got %p", $time, got);
            end else begin
                want = pending_results.pop_front();
                check_field("collided", want.collided, got.collided);
                check_field("overlap_x", want.ox, got.ox);
                check_field("overlap_y", want.oy, got.oy);
                check_field("overlap_w", want.ow, got.ow);
                check_field("overlap_h", want.oh, got.oh);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int ph, n;

        plan_check(0, 0, 0, 0, 1'b1, rect(0, 0, 64, 64));
        plan_check(-2048, -2048, -2048, -2048, 1'b1, rect(-2048, -2048, 64, 64));
        plan_check(2047, 2047, 2047, 2047, 1'b1, rect(2047, 2047, 64, 64));
        plan_check(0, 0, 64, 0, 1'b1, '0);
        plan_check(-2048, 0, 2047, 5, 1'b1, '0);
        plan_check(0, 0, 63, 63, 1'b1, rect(63, 63, 1, 1));
        plan_word(KIND_UNUSED, '1);
        plan_word(KIND_WR_A, pack_word(63, 63, '1, 0, 0, 0, 0));
        plan_word(KIND_WR_B, pack_word(0, 0, '0, 0, 0, 0, 0));
        plan_reg(REG_KEY_A, '1);
        plan_reg(REG_KEY_B, '0);
        plan_reg(REG_MODE_FLAGS, 32'h3);
        plan_check(0, 0, 63, 63, 1'b1, '0);
        plan_reg(REG_ALPHA_MASK, '1);
        plan_reg(REG_MODE_FLAGS, 32'hC);
        plan_check(0, 0, 63, 63, 1'b1, '0);
        plan_reg(REG_MODE_FLAGS, 32'h0);
        plan_reg(REG_WIDTH_A, 32'd127);
        plan_reg(REG_HEIGHT_A, 32'd127);
        plan_reg(REG_WIDTH_B, 32'd1);
        plan_reg(REG_HEIGHT_B, 32'd1);
        plan_check(0, 0, 10, 20, 1'b1, rect(10, 20, 1, 1));
        plan_check(0, 0, 63, 63, 1'b1, rect(63, 63, 1, 1));
        plan_check(0, 0, 64, 63, 1'b1, '0);
        plan_reg(REG_WIDTH_B, 32'd0);
        plan_check(0, 0, 0, 0, 1'b1, '0);
        plan_reg(REG_WIDTH_B, 32'd1);
        plan_reg(REG_HEIGHT_B, 32'd0);
        plan_check(0, 0, 0, 0, 1'b1, '0);
        plan_reg(REG_HEIGHT_B, 32'd1);
        plan_reg(REG_ALPHA_MASK, '0);
        plan_reg(REG_MODE_FLAGS, 32'hF);
        plan_check(0, 0, 0, 0, 1'b1, '0);
        plan_reg(REG_ALPHA_MASK, ALPHA_RST);
        plan_reg(REG_MODE_FLAGS, 32'h5);
        plan_check(-3, -3, 0, 0);
        plan_check(2040, -2048, 2047, -2048);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_REG) begin
                drain();
                reg_write(plan[i].idx, plan[i].val);
            end else begin
                issue(plan[i].kind, plan[i].data, plan[i].typed, plan[i].exp);
            end
        end

        for (ph = 0; ph < 4; ph++) begin
            drain();
            gap_pct = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            shuffle_regs();
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                if (ph == 1 && n == ITEMS_PER_PHASE / 2)
                    drain();
                if ($urandom_range(19) == 0) begin
                    send_word(KIND_UNUSED, {$urandom, $urandom, $urandom});
                end else begin
                    random_word();
                    n++;
                end
            end
        end

        drain();
        $display("Run covered %0d accepted words and %0d checks (%0d hits, %0d misses)",
                 n_words, n_checks, n_hits, n_misses);
        $display("over directed cases and four random handshake phases with varied registers");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/psc_pkg.sv
src/psc_ctrl.sv
src/psc_datapath.sv
src/pixel_sprite_collision_core.sv
sim/pixel_sprite_collision_core_tb.sv
